// File: design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the ring buffer deque
// Storage geometry, request/response payload types, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

	// storage geometry
	localparam int DEPTH   = 16;
	localparam int ITEM_W  = 32;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;

	// field widths of the channels
	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = 4;
	localparam int DATA_W  = 32;
	localparam int CAP_W   = 5;

	// capacity after reset, clamped to the storage depth
	localparam int CAP_RST = (16 > DEPTH) ? DEPTH : 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ_FRONT = 3'd4,
		CMD_READ_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               command;
		logic [VALUE_W-1:0] value;
		logic [IDX_W-1:0]   index;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              is_full;
		logic              is_empty;
	} rsp_t;

	// write port request into the cell store
	typedef struct packed {
		logic              en;
		logic [PTR_W-1:0]  addr;
		logic [ITEM_W-1:0] wdata;
	} store_wr_t;

endpackage

`default_nettype wire

// File: design/ring_buffer_deque_top.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque_top: double-ended circular buffer of 32-bit items
// Request register, single-pass command logic and response register.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries one command: push
//   back or front, pop back or front, or read at an index from either end.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   response per request: data, status, count and the full/empty flags.
//   cfg_we / cfg_wdata write the capacity (0 acts as 1, above 16 as 16);
//   a write also empties the buffer. Write it only while the block is idle.
// Flow:
//   A request is captured in the request register and its response in the
//   response register. One request per cycle is sustained while rsp_stall
//   is low; each command does one register-file access and one pointer
//   update while it is held in the request register.
// Reset:
//   Buffer empty, both pointers zero, capacity 16. Cells are not cleared.
// Stall:
//   While rsp_stall holds a valid response, the response register holds and
//   one more request may wait in the request register; then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque_top
	import rbd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	logic              valid_s1, valid_s2;
	req_t              req_s1;
	rsp_t              rsp_s2, rsp_next;
	logic              fire;
	store_wr_t         wr;
	logic [PTR_W-1:0]  raddr;
	logic [ITEM_W-1:0] rdata;

	// stage 1 moves on when the response register is free or being drained
	assign fire      = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && valid_s2 && rsp_stall;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.fire     (fire),
		.req_s1   (req_s1),
		.wr       (wr),
		.raddr    (raddr),
		.rdata    (rdata),
		.rsp_next (rsp_next)
	);

	rbd_store u_store (
		.clk  (clk),
		.wr   (wr),
		.raddr(raddr),
		.rdata(rdata)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire

// File: design/rbd_store.sv
// ----------------------------------------------------------------------------
// rbd_store: cell register file of the ring buffer deque
// DEPTH item cells, one write port and one asynchronous read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_store
	import rbd_pkg::*;
(
	input  wire logic              clk,
	input  wire store_wr_t         wr,
	input  wire logic [PTR_W-1:0]  raddr,
	output logic      [ITEM_W-1:0] rdata
);

	logic [ITEM_W-1:0] cells_q [DEPTH];

	// write port; cells hold no reset value
	always_ff @(posedge clk) begin
		if (wr.en) begin
			cells_q[wr.addr] <= wr.wdata;
		end
	end

	// read port, same cycle
	assign rdata = cells_q[raddr];

endmodule

`default_nettype wire

// File: design/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl: pointer and occupancy control of the ring buffer deque
// Decodes one command, drives the cell store and builds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ctrl
	import rbd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              fire,
	input  wire req_t              req_s1,
	output store_wr_t              wr,
	output logic      [PTR_W-1:0]  raddr,
	input  wire logic [ITEM_W-1:0] rdata,
	output rsp_t                   rsp_next
);

	logic [CNT_W-1:0] cap_q;
	logic [PTR_W-1:0] front_q, back_q;
	logic [CNT_W-1:0] occ_q;

	logic [PTR_W-1:0] front_n, back_n;
	logic [CNT_W-1:0] occ_n;
	logic [CNT_W-1:0] cap_wr;
	logic [SUM_W-1:0] cap_x, idx_x, occ_x;
	logic [SUM_W-1:0] pos_f, pos_b;
	logic             full_now, empty_now, idx_bad, take;
	status_t          status;

	// step forward with wrap at the capacity
	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
			input logic [SUM_W-1:0] cap);
		logic [SUM_W-1:0] nx;
		nx = SUM_W'(p) + SUM_W'(1);
		return (nx >= cap) ? '0 : PTR_W'(nx);
	endfunction

	// step back with wrap at the capacity
	function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p,
			input logic [SUM_W-1:0] cap);
		logic [SUM_W-1:0] px;
		px = SUM_W'(p);
		return (p == '0 || px >= cap) ? PTR_W'(cap - SUM_W'(1)) : PTR_W'(px - SUM_W'(1));
	endfunction

	// effective capacity of a register write
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_wr = CNT_W'(1);
		end else if (int'(cfg_wdata) > DEPTH) begin
			cap_wr = CNT_W'(DEPTH);
		end else begin
			cap_wr = CNT_W'(cfg_wdata);
		end
	end

	assign cap_x     = SUM_W'(cap_q);
	assign idx_x     = SUM_W'(req_s1.index);
	assign occ_x     = SUM_W'(occ_q);
	assign full_now  = (occ_q >= cap_q);
	assign empty_now = (occ_q == '0);
	assign idx_bad   = empty_now || (idx_x >= occ_x);

	// read positions; one subtract suffices since both sums stay below 2*cap
	always_comb begin
		pos_f = SUM_W'(front_q) + idx_x;
		if (pos_f >= cap_x) begin
			pos_f = pos_f - cap_x;
		end
		pos_b = SUM_W'(back_q) + cap_x - SUM_W'(1) - idx_x;
		if (pos_b >= cap_x) begin
			pos_b = pos_b - cap_x;
		end
	end

	// command decode
	always_comb begin
		front_n  = front_q;
		back_n   = back_q;
		occ_n    = occ_q;
		status   = ST_OK;
		take     = 1'b0;
		raddr    = front_q;
		wr.en    = 1'b0;
		wr.addr  = back_q;
		wr.wdata = ITEM_W'(req_s1.value);
		case (req_s1.command)
			CMD_PUSH_BACK: begin
				if (full_now) begin
					status = ST_FULL;
				end else begin
					wr.en   = fire;
					wr.addr = back_q;
					back_n  = wrap_inc(back_q, cap_x);
					occ_n   = occ_q + CNT_W'(1);
				end
			end
			CMD_PUSH_FRONT: begin
				if (full_now) begin
					status = ST_FULL;
				end else begin
					front_n = wrap_dec(front_q, cap_x);
					wr.en   = fire;
					wr.addr = front_n;
					occ_n   = occ_q + CNT_W'(1);
				end
			end
			CMD_POP_BACK: begin
				if (empty_now) begin
					status = ST_EMPTY;
				end else begin
					back_n = wrap_dec(back_q, cap_x);
					raddr  = back_n;
					take   = 1'b1;
					occ_n  = occ_q - CNT_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty_now) begin
					status = ST_EMPTY;
				end else begin
					raddr   = front_q;
					take    = 1'b1;
					front_n = wrap_inc(front_q, cap_x);
					occ_n   = occ_q - CNT_W'(1);
				end
			end
			CMD_READ_FRONT: begin
				if (idx_bad) begin
					status = ST_EMPTY;
				end else begin
					raddr = PTR_W'(pos_f);
					take  = 1'b1;
				end
			end
			CMD_READ_BACK: begin
				if (idx_bad) begin
					status = ST_EMPTY;
				end else begin
					raddr = PTR_W'(pos_b);
					take  = 1'b1;
				end
			end
			default: begin
				// unknown command: no change, data zero, status ok
			end
		endcase
	end

	// response
	always_comb begin
		rsp_next.data     = take ? DATA_W'(rdata) : '0;
		rsp_next.status   = status;
		rsp_next.count    = occ_n;
		rsp_next.is_full  = (occ_n == cap_q);
		rsp_next.is_empty = (occ_n == '0);
	end

	// capacity, pointers and occupancy; a capacity write empties the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(CAP_RST);
			front_q <= '0;
			back_q  <= '0;
			occ_q   <= '0;
		end else if (cfg_we) begin
			cap_q   <= cap_wr;
			front_q <= '0;
			back_q  <= '0;
			occ_q   <= '0;
		end else if (fire) begin
			front_q <= front_n;
			back_q  <= back_n;
			occ_q   <= occ_n;
		end
	end

endmodule

`default_nettype wire

// File: design/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker: port-level checks of the ring buffer deque
// Response consistency and output hold under stall, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_checker
	import rbd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// a stalled response stays and holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed under stall");

	// empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.count == '0)))
		else $error("is_empty disagrees with count");

	// a rejected push only happens on a full, non-empty buffer
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.is_full && !rsp.is_empty)
		else $error("push rejected while not full");

	// failed commands return zero data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.data == '0)
		else $error("failed command returned data");

	// request stall only when a response is held by the receiver
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held response");

endmodule

bind ring_buffer_deque_top rbd_checker u_rbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

`default_nettype wire

// File: tb/ring_buffer_deque_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_top_test: self-checking bench of the ring buffer deque
// A short directed table of requests, then random phases under several
// capacities and idle patterns. Every response is compared field by field
// with a pinned expected value or an in-bench deque model.
// ----------------------------------------------------------------------------

module ring_buffer_deque_top_test;
	import rbd_pkg::*;

	localparam int RSP_LATENCY = 2;
	localparam int MAX_REPORTS = 10;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 75;

	// command codes outside the enumerated set
	localparam cmd_t CMD_RSVD_A = cmd_t'(3'd6);
	localparam cmd_t CMD_RSVD_B = cmd_t'(3'd7);

	localparam logic [VALUE_W-1:0] ALL_ONES = '1;

	typedef struct {
		bit   pinned;
		rsp_t rsp;
	} typed_rsp_t;

	typedef struct {
		bit               is_cfg;
		logic [CAP_W-1:0] cap;
		req_t             rq;
		bit               pinned;
		rsp_t             rsp;
	} row_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	// deque model state
	logic [ITEM_W-1:0] dq_cells [DEPTH];
	logic [PTR_W-1:0]  dq_front    = '0;
	logic [PTR_W-1:0]  dq_back     = '0;
	logic [CNT_W-1:0]  dq_count    = '0;
	logic [CAP_W-1:0]  dq_capacity = CAP_W'(CAP_RST);

	rsp_t       awaited_rsp [$];
	typed_rsp_t typed_rsp [$];
	row_t       dir_rows [$];

	int unsigned errors    = 0;
	int unsigned send_idle = 0;
	int unsigned stall_pct = 0;
	bit          filling   = 1'b1;

	ring_buffer_deque_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// capacity in effect: zero acts as one, above the depth acts as the depth
	function automatic logic [CNT_W-1:0] used_depth();
		logic [CAP_W-1:0] c;
		c = dq_capacity;
		if (c == 0)
			c = CAP_W'(1);
		if (c > DEPTH)
			c = CAP_W'(DEPTH);
		return CNT_W'(c);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
		return (SUM_W'(p) + SUM_W'(1) >= SUM_W'(cap)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
		return (p == 0 || SUM_W'(p) >= SUM_W'(cap)) ? PTR_W'(cap - 1'b1) : p - 1'b1;
	endfunction

	// apply one request to the model deque, return its response
	function automatic rsp_t deque_apply(req_t r);
		logic [CNT_W-1:0] cap;
		logic [SUM_W-1:0] pos;
		rsp_t o;
		cap = used_depth();
		o = '0;
		o.status = ST_OK;
		case (r.command)
			CMD_PUSH_BACK: begin
				if (dq_count >= cap) begin
					o.status = ST_FULL;
				end else begin
					dq_cells[dq_back] = r.value;
					dq_back = ptr_next(dq_back, cap);
					dq_count = dq_count + 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (dq_count >= cap) begin
					o.status = ST_FULL;
				end else begin
					dq_front = ptr_prev(dq_front, cap);
					dq_cells[dq_front] = r.value;
					dq_count = dq_count + 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (dq_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					dq_back = ptr_prev(dq_back, cap);
					o.data = dq_cells[dq_back];
					dq_count = dq_count - 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (dq_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.data = dq_cells[dq_front];
					dq_front = ptr_next(dq_front, cap);
					dq_count = dq_count - 1'b1;
				end
			end
			CMD_READ_FRONT: begin
				if (dq_count == 0 || r.index >= dq_count) begin
					o.status = ST_EMPTY;
				end else begin
					pos = SUM_W'(dq_front) + SUM_W'(r.index);
					if (pos >= cap)
						pos = pos - cap;
					o.data = dq_cells[pos[PTR_W-1:0]];
				end
			end
			CMD_READ_BACK: begin
				if (dq_count == 0 || r.index >= dq_count) begin
					o.status = ST_EMPTY;
				end else begin
					pos = SUM_W'(SUM_W'(dq_back) + SUM_W'(cap) - 1 - SUM_W'(r.index));
					if (pos >= cap)
						pos = pos - cap;
					o.data = dq_cells[pos[PTR_W-1:0]];
				end
			end
			default: ;
		endcase
		o.count = dq_count;
		o.is_full = (dq_count == cap);
		o.is_empty = (dq_count == 0);
		return o;
	endfunction

	function automatic rsp_t mk_rsp(logic [DATA_W-1:0] d, status_t st, logic [CNT_W-1:0] cnt,
			logic full, logic empty);
		rsp_t o;
		o.data = d;
		o.status = st;
		o.count = cnt;
		o.is_full = full;
		o.is_empty = empty;
		return o;
	endfunction

	task automatic check_rsp(rsp_t got, rsp_t want);
		if (got.data !== want.data || got.status !== want.status || got.count !== want.count ||
				got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%0t: response mismatch, expected data %h status %0d count %0d",
					$realtime, want.data, want.status, want.count);
				$display("%0t:   expected full %b empty %b", $realtime,
					want.is_full, want.is_empty);
				$display("%0t:   got data %h status %0d count %0d full %b empty %b",
					$realtime, got.data, got.status, got.count, got.is_full, got.is_empty);
			end
		end
	endtask

	// track configuration and accepted requests, check accepted responses
	always @(posedge clk) begin
		typed_rsp_t t;
		rsp_t predicted;
		if (arst_n) begin
			if (cfg_we) begin
				dq_capacity = cfg_wdata;
				dq_front = '0;
				dq_back = '0;
				dq_count = '0;
			end
			if (req_valid && !req_stall) begin
				t = typed_rsp.pop_front();
				predicted = deque_apply(req);
				awaited_rsp.push_back(t.pinned ? t.rsp : predicted);
			end
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: response with no request outstanding, data %h status %0d",
							$realtime, rsp.data, rsp.status);
				end else begin
					check_rsp(rsp, awaited_rsp.pop_front());
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic add_req(cmd_t c, logic [VALUE_W-1:0] v, logic [IDX_W-1:0] i, bit pinned,
			rsp_t want);
		row_t row;
		row.is_cfg = 1'b0;
		row.cap = '0;
		row.rq.command = c;
		row.rq.value = v;
		row.rq.index = i;
		row.pinned = pinned;
		row.rsp = want;
		dir_rows.push_back(row);
	endtask

	task automatic add_cap(logic [CAP_W-1:0] cap);
		row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cap = cap;
		dir_rows.push_back(row);
	endtask

	// present one request and hold it until taken, then maybe idle
	task automatic send_req(req_t r, bit pinned, rsp_t want);
		typed_rsp.push_back('{pinned, want});
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop sending until every response is back and the pipeline is empty
	task automatic drain();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0 || typed_rsp.size() != 0)
			@(posedge clk);
		repeat (RSP_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random request, biased to fill the deque and then drain it again
	function automatic req_t random_req();
		req_t r;
		int unsigned pick;
		int unsigned push_pct;
		int unsigned pop_pct;
		logic [CNT_W-1:0] cap;
		cap = used_depth();
		if (dq_count >= cap)
			filling = 1'b0;
		else if (dq_count == 0)
			filling = 1'b1;
		else if ($urandom_range(99) < 3)
			filling = !filling;
		push_pct = filling ? 65 : 20;
		pop_pct = filling ? 15 : 55;
		case ($urandom_range(9))
			0: r.value = '0;
			1: r.value = ALL_ONES;
			default: r.value = $urandom;
		endcase
		r.index = IDX_W'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 3) begin
			r.command = $urandom_range(1) ? CMD_RSVD_A : CMD_RSVD_B;
		end else if (pick < 3 + push_pct) begin
			r.command = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		end else if (pick < 3 + push_pct + pop_pct) begin
			r.command = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
		end else begin
			r.command = $urandom_range(1) ? CMD_READ_BACK : CMD_READ_FRONT;
			// mostly in range, sometimes any index
			if (dq_count != 0 && $urandom_range(3) != 0)
				r.index = IDX_W'($urandom_range(dq_count - 1));
		end
		return r;
	endfunction

	initial begin
		logic [CAP_W-1:0] phase_cap [N_PHASES];
		int unsigned phase_send [N_PHASES];
		int unsigned phase_stall [N_PHASES];
		phase_cap   = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd17, 5'd0, 5'd16, 5'd9};
		phase_send  = '{0, 58, 0, 23, 0, 23, 58, 0};
		phase_stall = '{0, 0, 58, 23, 0, 23, 0, 58};
		phase_cap[7] = CAP_W'($urandom_range(2, 15));

		// empty deque after reset, capacity 16
		add_req(CMD_POP_BACK, '0, 4'd0, 1'b1, mk_rsp('0, ST_EMPTY, 5'd0, 1'b0, 1'b1));
		add_req(CMD_POP_FRONT, '0, 4'd0, 1'b1, mk_rsp('0, ST_EMPTY, 5'd0, 1'b0, 1'b1));
		add_req(CMD_READ_FRONT, '0, 4'd0, 1'b1, mk_rsp('0, ST_EMPTY, 5'd0, 1'b0, 1'b1));
		add_req(CMD_READ_BACK, ALL_ONES, 4'd15, 1'b1, mk_rsp('0, ST_EMPTY, 5'd0, 1'b0, 1'b1));
		add_req(CMD_RSVD_A, '0, 4'd0, 1'b1, mk_rsp('0, ST_OK, 5'd0, 1'b0, 1'b1));
		// pushes at both ends with extreme values
		add_req(CMD_PUSH_BACK, ALL_ONES, 4'd15, 1'b1, mk_rsp('0, ST_OK, 5'd1, 1'b0, 1'b0));
		add_req(CMD_PUSH_FRONT, '0, 4'd0, 1'b1, mk_rsp('0, ST_OK, 5'd2, 1'b0, 1'b0));
		add_req(CMD_PUSH_BACK, 32'hA5A5_5A5A, 4'd7, 1'b1, mk_rsp('0, ST_OK, 5'd3, 1'b0, 1'b0));
		// reads from both ends, index out of range
		add_req(CMD_READ_FRONT, '0, 4'd0, 1'b1, mk_rsp('0, ST_OK, 5'd3, 1'b0, 1'b0));
		add_req(CMD_READ_BACK, '0, 4'd0, 1'b1,
			mk_rsp(32'hA5A5_5A5A, ST_OK, 5'd3, 1'b0, 1'b0));
		add_req(CMD_READ_FRONT, '0, 4'd3, 1'b1, mk_rsp('0, ST_EMPTY, 5'd3, 1'b0, 1'b0));
		add_req(CMD_READ_FRONT, '0, 4'd2, 1'b0, '0);
		add_req(CMD_RSVD_B, ALL_ONES, 4'd15, 1'b0, '0);
		// pops back to empty
		add_req(CMD_POP_FRONT, '0, 4'd0, 1'b0, '0);
		add_req(CMD_POP_BACK, '0, 4'd0, 1'b0, '0);
		add_req(CMD_POP_BACK, '0, 4'd0, 1'b0, '0);
		add_req(CMD_POP_FRONT, '0, 4'd0, 1'b1, mk_rsp('0, ST_EMPTY, 5'd0, 1'b0, 1'b1));
		// capacity zero acts as one: full after one push
		add_cap(5'd0);
		add_req(CMD_PUSH_BACK, 32'h0123_4567, 4'd0, 1'b1, mk_rsp('0, ST_OK, 5'd1, 1'b1, 1'b0));
		add_req(CMD_PUSH_FRONT, ALL_ONES, 4'd0, 1'b1, mk_rsp('0, ST_FULL, 5'd1, 1'b1, 1'b0));
		add_req(CMD_READ_BACK, '0, 4'd0, 1'b0, '0);
		add_req(CMD_POP_FRONT, '0, 4'd0, 1'b0, '0);
		// capacity above the depth acts as the depth; front push wraps
		add_cap(5'd31);
		add_req(CMD_PUSH_FRONT, 32'h8000_0001, 4'd0, 1'b1, mk_rsp('0, ST_OK, 5'd1, 1'b0, 1'b0));
		add_req(CMD_READ_BACK, '0, 4'd0, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_capacity(dir_rows[i].cap);
			else
				send_req(dir_rows[i].rq, dir_rows[i].pinned, dir_rows[i].rsp);
		end

		// random phases, each with its own capacity and idle pattern
		for (int p = 0; p < N_PHASES; p++) begin
			write_capacity(phase_cap[p]);
			send_idle = phase_send[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain();
				send_req(random_req(), 1'b0, '0);
			end
		end

		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#200000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
design/rbd_pkg.sv
design/rbd_store.sv
design/rbd_ctrl.sv
design/ring_buffer_deque_top.sv
design/rbd_checker.sv
tb/ring_buffer_deque_top_test.sv
